// File: rtl/sapl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sapl_pkg;

	localparam int ANGLE_FRAC_BITS = 6;
	localparam int ANGLE_W = 15;
	localparam int APB_ADDR_W = 5;

	localparam logic [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(360 << ANGLE_FRAC_BITS);
	localparam logic [10:0] STEADY_LIMIT = 11'd1000;
	localparam logic [9:0] INTEGRAL_CLEAR_LIMIT = 10'd1000;

	localparam int D_SCALE = 4000 << ANGLE_FRAC_BITS;
	localparam logic signed [18:0] BAND = 19'(6 << ANGLE_FRAC_BITS);
	localparam logic signed [28:0] S_MAX = 29'(200 * D_SCALE);
	localparam logic signed [28:0] S_MIN = -S_MAX;
	localparam logic signed [29:0] N_BASE_POS = 30'(1530 * D_SCALE);
	localparam logic signed [29:0] N_BASE_ZERO = 30'(1500 * D_SCALE);
	localparam logic signed [29:0] N_BASE_NEG = 30'(1470 * D_SCALE);
	localparam int CMP_SHIFT = 16;
	localparam longint CMP_DIVISOR = longint'(20000 * 4000) >> (CMP_SHIFT - ANGLE_FRAC_BITS);
	localparam int RECIP_SHIFT = 46;
	localparam logic [29:0] RECIP_MUL =
		30'(((longint'(1) << RECIP_SHIFT) + CMP_DIVISOR - 1) / CMP_DIVISOR);
	localparam logic signed [27:0] ES_MAX = 28'sd67108863;
	localparam logic signed [27:0] ES_MIN = -28'sd67108864;

	localparam logic KIND_MOVE = 1'b0;
	localparam logic LEVEL_RISE = 1'b1;

	typedef enum logic [2:0] {
		REG_PERIOD_COUNT = 3'd0,
		REG_FEEDBACK_MIN_DUTY = 3'd1,
		REG_FEEDBACK_MAX_DUTY = 3'd2,
		REG_PWM_PERIOD = 3'd3,
		REG_STOP_COMPARE = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] period_count;
		logic [15:0] feedback_min_duty;
		logic [15:0] feedback_max_duty;
		logic [15:0] pwm_period;
		logic [15:0] stop_compare;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic full;
		logic [31:0] dividend;
		logic [16:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [31:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic [15:0] compare_value;
		logic settled;
		logic [ANGLE_W-1:0] measured_angle;
	} result_t;

endpackage
`default_nettype wire

// File: rtl/sapl_evt_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sapl_evt_if;
	logic valid;
	logic ready;
	logic kind;
	logic [8:0] move_angle;
	logic direction;
	logic [15:0] capture_time;
	logic edge_level;

	modport source (output valid, kind, move_angle, direction, capture_time, edge_level,
		input ready);
	modport sink (input valid, kind, move_angle, direction, capture_time, edge_level,
		output ready);
endinterface
`default_nettype wire

// File: rtl/sapl_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sapl_res_if;
	logic valid;
	logic ready;
	logic [15:0] compare_value;
	logic settled;
	logic [14:0] measured_angle;

	modport source (output valid, compare_value, settled, measured_angle, input ready);
	modport sink (input valid, compare_value, settled, measured_angle, output ready);
endinterface
`default_nettype wire

// File: rtl/servo_angle_pi_loop_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  handshake             payload
// evt      in   valid/ready           kind, move_angle, direction, capture_time, edge_level
// res      out  valid/ready           compare_value, settled, measured_angle
// apb      in   psel/penable/pready   paddr[4:2] register, pwdata/prdata low 16 bits
//
// A command or a rising edge is handled in the idle state. A falling edge that closes a pulse
// uses 32 steps of the shared divider for duty and 16 for the angle, then the error, PI,
// multiply and compare states; the compare value comes from a reciprocal multiply. A duty
// at or outside the span skips the angle divide; a settling pulse skips PI, multiply and compare.
// arst_n clears the loop state and loads the register reset values.
// A result beat waits in the output register; the next beat is taken meanwhile, and a
// further result holds the sequencer until the output register frees.
module servo_angle_pi_loop_top (
	input logic clk,
	input logic arst_n,
	sapl_evt_if.sink evt,
	sapl_res_if.source res,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [sapl_pkg::APB_ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import sapl_pkg::*;

	cfg_t cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;

	sapl_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	sapl_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	sapl_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt),
		.res(res),
		.cfg(cfg),
		.div_req(div_req),
		.div_rsp(div_rsp)
	);
endmodule
`default_nettype wire

// File: rtl/sapl_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module sapl_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [sapl_pkg::APB_ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output sapl_pkg::cfg_t cfg
);
	import sapl_pkg::*;

	logic wr;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && pready;
	assign idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.period_count <= 16'd1100;
			cfg.feedback_min_duty <= 16'd1901;
			cfg.feedback_max_duty <= 16'd63569;
			cfg.pwm_period <= 16'd19999;
			cfg.stop_compare <= 16'd1500;
		end else if (wr) begin
			unique case (idx)
				REG_PERIOD_COUNT: cfg.period_count <= pwdata[15:0];
				REG_FEEDBACK_MIN_DUTY: cfg.feedback_min_duty <= pwdata[15:0];
				REG_FEEDBACK_MAX_DUTY: cfg.feedback_max_duty <= pwdata[15:0];
				REG_PWM_PERIOD: cfg.pwm_period <= pwdata[15:0];
				REG_STOP_COMPARE: cfg.stop_compare <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PERIOD_COUNT: prdata = {16'h0, cfg.period_count};
			REG_FEEDBACK_MIN_DUTY: prdata = {16'h0, cfg.feedback_min_duty};
			REG_FEEDBACK_MAX_DUTY: prdata = {16'h0, cfg.feedback_max_duty};
			REG_PWM_PERIOD: prdata = {16'h0, cfg.pwm_period};
			REG_STOP_COMPARE: prdata = {16'h0, cfg.stop_compare};
			default: prdata = 32'h0;
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/sapl_div.sv
`timescale 1ns / 1ps
`default_nettype none
module sapl_div (
	input logic clk,
	input logic arst_n,
	input sapl_pkg::div_req_t req,
	output sapl_pkg::div_rsp_t rsp
);
	import sapl_pkg::*;

	localparam logic [5:0] FULL_STEPS = 6'd32;
	localparam logic [5:0] HALF_STEPS = 6'd16;

	logic [16:0] rem_q;
	logic [16:0] dsr_q;
	logic [31:0] num_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [17:0] sh;
	logic [18:0] diff;
	logic ge;

	assign sh = {rem_q, num_q[31]};
	assign diff = {1'b0, sh} - {2'b00, dsr_q};
	assign ge = ~diff[18];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.full ? FULL_STEPS : HALF_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dsr_q <= req.divisor;
			if (req.full) begin
				rem_q <= '0;
				num_q <= req.dividend;
			end else begin
				rem_q <= {1'b0, req.dividend[31:16]};
				num_q <= {req.dividend[15:0], 16'h0};
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff[16:0] : sh[16:0];
			num_q <= {num_q[30:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = num_q;
endmodule
`default_nettype wire

// File: rtl/sapl_core.sv
`timescale 1ns / 1ps
`default_nettype none
module sapl_core (
	input logic clk,
	input logic arst_n,
	sapl_evt_if.sink evt,
	sapl_res_if.source res,
	input sapl_pkg::cfg_t cfg,
	output sapl_pkg::div_req_t div_req,
	input sapl_pkg::div_rsp_t div_rsp
);
	import sapl_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_DUTY = 8'b0000_0010,
		ST_ANGLE = 8'b0000_0100,
		ST_ERR = 8'b0000_1000,
		ST_PI = 8'b0001_0000,
		ST_MUL = 8'b0010_0000,
		ST_CMP = 8'b0100_0000,
		ST_WRITE = 8'b1000_0000
	} state_t;

	state_t state_q, state_n;
	logic active_q, active_n;
	logic await_q, await_n;
	logic [15:0] rise_q, rise_n;
	logic [ANGLE_W-1:0] cur_q, cur_n;
	logic [ANGLE_W-1:0] tgt_q, tgt_n;
	logic signed [26:0] es_q, es_n;
	logic [10:0] steady_q, steady_n;
	logic [9:0] sample_q, sample_n;
	logic out_valid_q;
	result_t out_q;
	result_t pend_q, pend_n;
	logic [ANGLE_W-1:0] det_q, det_n;
	logic signed [15:0] e_q, e_n;
	logic [28:0] n_q, n_n;
	logic [28:0] scaled_q, scaled_n;

	logic evt_acc;
	logic load_out;
	logic settle;
	logic [ANGLE_W-1:0] turn;
	logic [16:0] cw0, cw1, cw2, ccw0, ccw1, ccw2, ft17;
	logic [ANGLE_W-1:0] tg;
	logic [15:0] width;
	logic [15:0] per;
	logic [31:0] duty;
	logic [31:0] x;
	logic [15:0] rng;
	logic signed [15:0] e_err;
	logic signed [18:0] e5_err, e5_pi;
	logic in_band;
	logic signed [28:0] e_x, es_x, s_raw, s_clip;
	logic signed [29:0] n_base, n_w;
	logic signed [27:0] es_add;
	logic [9:0] sample_inc;
	logic [44:0] prod;
	logic [58:0] recip;

	assign evt_acc = evt.valid && evt.ready;
	assign evt.ready = (state_q == ST_IDLE);

	assign ft17 = {2'b00, FULL_TURN};
	assign turn = ANGLE_W'(evt.move_angle) << ANGLE_FRAC_BITS;
	assign cw0 = {2'b00, cur_q} - {2'b00, turn};
	assign cw1 = cw0[16] ? cw0 + ft17 : cw0;
	assign cw2 = cw1[16] ? cw1 + ft17 : cw1;
	assign ccw0 = {2'b00, cur_q} + {2'b00, turn};
	assign ccw1 = (ccw0 > ft17) ? ccw0 - ft17 : ccw0;
	assign ccw2 = (ccw1 > ft17) ? ccw1 - ft17 : ccw1;
	assign tg = evt.direction ? ccw2[ANGLE_W-1:0] : cw2[ANGLE_W-1:0];

	assign width = evt.capture_time - rise_q;
	assign per = (cfg.period_count == 16'h0) ? 16'd1 : cfg.period_count;
	assign duty = div_rsp.quotient;
	assign x = duty - {16'h0, cfg.feedback_min_duty};
	assign rng = cfg.feedback_max_duty - cfg.feedback_min_duty;

	assign e_err = $signed({1'b0, det_q}) - $signed({1'b0, tgt_q});
	assign e5_err = $signed({{3{e_err[15]}}, e_err}) * 19'sd5;
	assign in_band = (e5_err < BAND) && (e5_err > -BAND);

	assign e5_pi = $signed({{3{e_q[15]}}, e_q}) * 19'sd5;
	assign e_x = $signed({{13{e_q[15]}}, e_q});
	assign es_x = $signed({{2{es_q[26]}}, es_q});
	assign s_raw = e_x * 29'sd101 + es_x;
	assign s_clip = (s_raw > S_MAX) ? S_MAX : ((s_raw < S_MIN) ? S_MIN : s_raw);
	assign n_base = (e5_pi > BAND) ? N_BASE_POS : ((e5_pi < -BAND) ? N_BASE_NEG : N_BASE_ZERO);
	assign n_w = n_base + $signed({s_clip[28], s_clip});
	assign es_add = $signed({es_q[26], es_q}) + $signed({{12{e_q[15]}}, e_q});
	assign sample_inc = sample_q + 10'd1;
	assign prod = {16'h0, n_q} * {29'h0, cfg.pwm_period};
	assign recip = {30'h0, scaled_q} * {29'h0, RECIP_MUL};

	always_comb begin
		state_n = state_q;
		active_n = active_q;
		await_n = await_q;
		rise_n = rise_q;
		cur_n = cur_q;
		tgt_n = tgt_q;
		es_n = es_q;
		steady_n = steady_q;
		sample_n = sample_q;
		pend_n = pend_q;
		det_n = det_q;
		e_n = e_q;
		n_n = n_q;
		scaled_n = scaled_q;
		div_req = '0;
		load_out = 1'b0;
		settle = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (evt_acc) begin
					if (evt.kind == KIND_MOVE) begin
						tgt_n = tg;
						active_n = 1'b1;
						await_n = 1'b0;
						es_n = '0;
						steady_n = '0;
						sample_n = '0;
					end else if (active_q) begin
						if (!await_q) begin
							if (evt.edge_level == LEVEL_RISE) begin
								rise_n = evt.capture_time;
								await_n = 1'b1;
							end
						end else if (evt.edge_level != LEVEL_RISE) begin
							await_n = 1'b0;
							div_req.start = 1'b1;
							div_req.full = 1'b1;
							div_req.dividend = {width, 16'h0};
							div_req.divisor = {1'b0, per};
							state_n = ST_DUTY;
						end
					end
				end
			end
			ST_DUTY: begin
				if (div_rsp.done) begin
					if (cfg.feedback_max_duty <= cfg.feedback_min_duty ||
							duty <= {16'h0, cfg.feedback_min_duty}) begin
						det_n = '0;
						state_n = ST_ERR;
					end else if (x >= {16'h0, rng}) begin
						det_n = FULL_TURN;
						state_n = ST_ERR;
					end else begin
						div_req.start = 1'b1;
						div_req.full = 1'b0;
						div_req.dividend = {16'h0, x[15:0]} * {17'h0, FULL_TURN};
						div_req.divisor = {1'b0, rng};
						state_n = ST_ANGLE;
					end
				end
			end
			ST_ANGLE: begin
				if (div_rsp.done) begin
					det_n = div_rsp.quotient[ANGLE_W-1:0];
					state_n = ST_ERR;
				end
			end
			ST_ERR: begin
				if (in_band && steady_q > STEADY_LIMIT) begin
					settle = 1'b1;
					pend_n.compare_value = cfg.stop_compare;
					pend_n.settled = 1'b1;
					pend_n.measured_angle = det_q;
					cur_n = det_q;
					active_n = 1'b0;
					state_n = ST_WRITE;
				end else begin
					steady_n = in_band ? steady_q + 11'd1 : 11'd0;
					e_n = e_err;
					state_n = ST_PI;
				end
			end
			ST_PI: begin
				n_n = n_w[28:0];
				if (es_add > ES_MAX) begin
					es_n = ES_MAX[26:0];
				end else if (es_add < ES_MIN) begin
					es_n = ES_MIN[26:0];
				end else begin
					es_n = es_add[26:0];
				end
				sample_n = sample_inc;
				if (sample_inc > INTEGRAL_CLEAR_LIMIT) begin
					sample_n = '0;
					es_n = '0;
				end
				state_n = ST_MUL;
			end
			ST_MUL: begin
				scaled_n = prod[44:CMP_SHIFT];
				state_n = ST_CMP;
			end
			ST_CMP: begin
				pend_n.compare_value = {3'b000, recip[58:RECIP_SHIFT]};
				pend_n.settled = 1'b0;
				pend_n.measured_angle = det_q;
				state_n = ST_WRITE;
			end
			ST_WRITE: begin
				if (!out_valid_q || res.ready) begin
					load_out = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			active_q <= 1'b0;
			await_q <= 1'b0;
			rise_q <= '0;
			cur_q <= '0;
			tgt_q <= '0;
			es_q <= '0;
			steady_q <= '0;
			sample_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			active_q <= active_n;
			await_q <= await_n;
			rise_q <= rise_n;
			cur_q <= cur_n;
			tgt_q <= tgt_n;
			es_q <= es_n;
			steady_q <= steady_n;
			sample_q <= sample_n;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_n;
		det_q <= det_n;
		e_q <= e_n;
		n_q <= n_n;
		scaled_q <= scaled_n;
		if (load_out) begin
			out_q <= pend_q;
		end
	end

	assign res.valid = out_valid_q;
	assign res.compare_value = out_q.compare_value;
	assign res.settled = out_q.settled;
	assign res.measured_angle = out_q.measured_angle;

	a_settle_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		settle |=> !active_q && state_q == ST_WRITE)
		else $error("settle did not disarm the loop");

	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		tgt_q <= FULL_TURN && cur_q <= FULL_TURN)
		else $error("angle state out of range");

	a_out_angle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.measured_angle <= FULL_TURN)
		else $error("measured angle out of range");

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		steady_q <= STEADY_LIMIT + 11'd1 && sample_q <= INTEGRAL_CLEAR_LIMIT)
		else $error("sample counters overran");

	a_integral_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PI && sample_inc > INTEGRAL_CLEAR_LIMIT) |=> es_q == 27'sd0)
		else $error("integral not cleared");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !out_valid_q || res.ready)
		else $error("result beat overwritten");
endmodule
`default_nettype wire
